[design/assert_macros.svh]
// Assertion macros for the port checker of the lane tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define CHK_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/swlt_pkg.sv]
// Package with types, codes and the control program of the lane tracker.
`timescale 1ns / 1ps
`default_nettype none
package swlt_pkg;

	localparam int IMG_W_DEF = 320;
	localparam int IMG_H_DEF = 320;

	localparam int S_TDATA_W = 32;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 24;
	localparam int M_TUSER_W = 2;
	localparam int CFG_W     = 7;
	localparam int PADDR_W   = 3;

	localparam logic [CFG_W-1:0] WIN_W_RST = 7'd40;
	localparam logic [CFG_W-1:0] WIN_H_RST = 7'd20;
	localparam logic [CFG_W-1:0] WIN_W_MIN = 7'd2;
	localparam logic [CFG_W-1:0] WIN_W_MAX = 7'd64;
	localparam logic [CFG_W-1:0] WIN_H_MIN = 7'd8;
	localparam logic [CFG_W-1:0] WIN_H_MAX = 7'd64;
	localparam int MAX_WIN = 40;

	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;
	localparam logic SIDE_LEFT   = 1'b0;
	localparam logic SIDE_RIGHT  = 1'b1;
	localparam logic REG_WIN_H   = 1'b1;

	localparam logic [M_TUSER_W-1:0] KIND_START   = 2'd0;
	localparam logic [M_TUSER_W-1:0] KIND_HIT     = 2'd1;
	localparam logic [M_TUSER_W-1:0] KIND_MISS    = 2'd2;
	localparam logic [M_TUSER_W-1:0] KIND_NOSTART = 2'd3;

	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t ST_IDLE    = 4'd0;
	localparam step_t ST_COLINIT = 4'd1;
	localparam step_t ST_READ    = 4'd2;
	localparam step_t ST_TEST    = 4'd3;
	localparam step_t ST_ROWNEXT = 4'd4;
	localparam step_t ST_COLNEXT = 4'd5;
	localparam step_t ST_MISS    = 4'd6;
	localparam step_t ST_MISSRET = 4'd7;
	localparam step_t ST_HIT     = 4'd8;
	localparam step_t ST_HITRET  = 4'd9;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_COLINIT,
		OP_READ,
		OP_COLNEXT,
		OP_MISS,
		OP_HIT
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NOGO,
		C_PIX,
		C_ROWMORE,
		C_COLMORE,
		C_MORE
	} cond_t;

	typedef struct packed {
		op_t   op;
		logic  emit;
		cond_t cond;
		step_t target;
	} uword_t;

	function automatic uword_t ucode(input step_t step);
		uword_t uw;
		unique case (step)
			ST_IDLE:    uw = '{op: OP_ACCEPT,  emit: 1'b0, cond: C_NOGO,    target: ST_IDLE};
			ST_COLINIT: uw = '{op: OP_COLINIT, emit: 1'b0, cond: C_NEVER,   target: ST_IDLE};
			ST_READ:    uw = '{op: OP_READ,    emit: 1'b0, cond: C_NEVER,   target: ST_IDLE};
			ST_TEST:    uw = '{op: OP_NONE,    emit: 1'b0, cond: C_PIX,     target: ST_HIT};
			ST_ROWNEXT: uw = '{op: OP_NONE,    emit: 1'b0, cond: C_ROWMORE, target: ST_READ};
			ST_COLNEXT: uw = '{op: OP_COLNEXT, emit: 1'b0, cond: C_COLMORE, target: ST_READ};
			ST_MISS:    uw = '{op: OP_MISS,    emit: 1'b1, cond: C_MORE,    target: ST_COLINIT};
			ST_MISSRET: uw = '{op: OP_NONE,    emit: 1'b0, cond: C_ALWAYS,  target: ST_IDLE};
			ST_HIT:     uw = '{op: OP_HIT,     emit: 1'b1, cond: C_MORE,    target: ST_COLINIT};
			ST_HITRET:  uw = '{op: OP_NONE,    emit: 1'b0, cond: C_ALWAYS,  target: ST_IDLE};
			default:    uw = '{op: OP_NONE,    emit: 1'b0, cond: C_ALWAYS,  target: ST_IDLE};
		endcase
		return uw;
	endfunction

endpackage
`default_nettype wire

[design/swlt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module swlt_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[design/sliding_window_lane_tracker.sv]
// Top level of the sliding-window lane tracker: frame store and window sequencer.
//
//  channel | dir | handshake                   | beat
//  s_*     | in  | s_tvalid / s_tready         | load pixel or start a search
//  m_*     | out | m_tvalid / m_tready         | start, hit, miss or no-start point
//  apb     | in  | psel & penable, pready = 1  | window width / height registers
//
// A load beat leaves the sequencer idle; beats are taken only in the idle step and
// while the output register can take a result.
// A search opens each window, then scans it column by column, reading the frame
// store row by row (read, test and next-row steps) until a set pixel gives a hit
// or the last column a miss, bound by the single read port of the frame store.
// Reset sets the config registers, control and m_tvalid, not the output data; the frame store has no clearing pass.
// A stalled m_tready holds the sequencer at its next result step.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_lane_tracker #(
	parameter int IMAGE_WIDTH  = swlt_pkg::IMG_W_DEF,
	parameter int IMAGE_HEIGHT = swlt_pkg::IMG_H_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// pixel[7:0], start_valid[8], start_x[17:9], start_y[26:18], lane_side[27], zero
	input  wire logic [swlt_pkg::S_TDATA_W-1:0] s_tdata,
	// mode[0]
	input  wire logic [swlt_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// point_x[8:0], point_y[17:9], zero
	output logic      [swlt_pkg::M_TDATA_W-1:0] m_tdata,
	// kind[1:0]
	output logic      [swlt_pkg::M_TUSER_W-1:0] m_tuser,
	output logic                               m_tlast,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [swlt_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready
);

	import swlt_pkg::*;

	localparam int PIXELS   = IMAGE_WIDTH * IMAGE_HEIGHT;
	localparam int AW       = $clog2(PIXELS);
	localparam int XB       = $clog2(IMAGE_WIDTH);
	localparam int YB       = $clog2(IMAGE_HEIGHT);
	localparam int DIM_BITS = (XB > YB) ? XB : YB;
	localparam int CW       = ((DIM_BITS > 9) ? DIM_BITS : 9) + 3;

	typedef logic signed [CW-1:0] coord_t;

	function automatic logic win_fits(input coord_t l, input coord_t t,
			input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		logic signed [CW:0] le;
		logic signed [CW:0] te;
		le = $signed((CW+1)'(l)) + $signed({{(CW-CFG_W+1){1'b0}}, w});
		te = $signed((CW+1)'(t)) + $signed({{(CW-CFG_W+1){1'b0}}, h});
		return !l[CW-1] && !t[CW-1] &&
			(le <= $signed((CW+1)'(IMAGE_WIDTH))) &&
			(te <= $signed((CW+1)'(IMAGE_HEIGHT)));
	endfunction

	// configuration
	logic [CFG_W-1:0] win_w_q, win_h_q, w_eff, h_eff, hw, hh;
	logic             cfg_we;

	// sequencer and datapath
	step_t            step_q, step_d;
	uword_t           uw;
	logic             hold, cond_ok;
	coord_t           left_q, top_q, prev_q;
	logic [5:0]       m_q;
	logic [CFG_W-1:0] r_q;
	logic             side_q;
	logic [5:0]       cnt_q;
	logic [AW-1:0]    ld_pos_q;

	// input unpack
	logic       mode, start_valid, lane_side;
	logic [7:0] pixel;
	logic [8:0] start_x, start_y;
	logic       acc, ld, srch, fit0, go;
	coord_t     sx, sy, l0, t0;

	// window arithmetic
	coord_t     cx, nl, nt, row, col, hit_y;
	logic       more, col_more;
	logic [AW-1:0] rd_addr;
	logic       rd_en, rd_bit;

	// output register
	logic       out_free, emit_now;
	logic [M_TUSER_W-1:0] kind_d;
	logic [8:0] px_d, py_d;
	logic       last_d;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;
	assign prdata = {{(32-CFG_W){1'b0}}, (paddr[2] == REG_WIN_H) ? win_h_q : win_w_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_w_q <= WIN_W_RST;
			win_h_q <= WIN_H_RST;
		end else if (cfg_we) begin
			if (paddr[2] == REG_WIN_H) begin
				win_h_q <= pwdata[CFG_W-1:0];
			end else begin
				win_w_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	always_comb begin
		priority if (win_w_q < WIN_W_MIN) w_eff = WIN_W_MIN;
		else if (win_w_q > WIN_W_MAX) w_eff = WIN_W_MAX;
		else w_eff = win_w_q;
		priority if (win_h_q < WIN_H_MIN) h_eff = WIN_H_MIN;
		else if (win_h_q > WIN_H_MAX) h_eff = WIN_H_MAX;
		else h_eff = win_h_q;
	end

	assign hw = w_eff >> 1;
	assign hh = h_eff >> 1;

	assign pixel       = s_tdata[7:0];
	assign start_valid = s_tdata[8];
	assign start_x     = s_tdata[17:9];
	assign start_y     = s_tdata[26:18];
	assign lane_side   = s_tdata[27];
	assign mode        = s_tuser[0];

	assign uw       = ucode(step_q);
	assign out_free = !m_tvalid || m_tready;
	assign hold     = uw.emit && !out_free;

	assign s_tready = (uw.op == OP_ACCEPT) && out_free;
	assign acc      = s_tvalid && s_tready;
	assign ld       = acc && (mode == MODE_LOAD);
	assign srch     = acc && (mode == MODE_SEARCH);

	assign sx   = coord_t'(start_x);
	assign sy   = coord_t'(start_y);
	assign l0   = sx - coord_t'(hw);
	assign t0   = sy - coord_t'(h_eff);
	assign fit0 = win_fits(l0, t0, w_eff, h_eff);
	assign go   = srch && start_valid && fit0;

	assign cx    = (uw.op == OP_HIT) ? (left_q + coord_t'(m_q)) : (left_q + coord_t'(hw));
	assign nl    = (cx <<< 1) - prev_q - coord_t'(hw);
	assign nt    = top_q - coord_t'(h_eff);
	assign hit_y = top_q + coord_t'(hh);
	assign more  = win_fits(nl, nt, w_eff, h_eff) && (cnt_q != 6'(MAX_WIN - 1));

	assign col_more = (side_q == SIDE_RIGHT) ? (m_q != 6'd0) : (m_q != 6'(w_eff - 7'd1));

	assign row     = top_q + coord_t'(r_q);
	assign col     = left_q + coord_t'(m_q);
	assign rd_addr = AW'(AW'(row[YB-1:0]) * AW'(IMAGE_WIDTH)) + AW'(col[XB-1:0]);
	assign rd_en   = (uw.op == OP_READ);

	swlt_ram #(
		.WIDTH (1),
		.DEPTH (PIXELS)
	) u_frame (
		.clk   (clk),
		.we    (ld),
		.waddr (ld_pos_q),
		.wdata (pixel != 8'd0),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_bit)
	);

	always_comb begin
		unique case (uw.cond)
			C_NEVER:   cond_ok = 1'b0;
			C_ALWAYS:  cond_ok = 1'b1;
			C_NOGO:    cond_ok = !go;
			C_PIX:     cond_ok = rd_bit;
			C_ROWMORE: cond_ok = (r_q < h_eff);
			C_COLMORE: cond_ok = col_more;
			C_MORE:    cond_ok = more;
			default:   cond_ok = 1'b0;
		endcase
		if (hold) begin
			step_d = step_q;
		end else if (cond_ok) begin
			step_d = uw.target;
		end else begin
			step_d = step_q + step_t'(1);
		end
	end

	always_comb begin
		emit_now = 1'b0;
		kind_d   = KIND_NOSTART;
		px_d     = 9'd0;
		py_d     = 9'd0;
		last_d   = 1'b1;
		if (srch) begin
			emit_now = 1'b1;
			if (start_valid) begin
				kind_d = KIND_START;
				px_d   = start_x;
				py_d   = start_y;
				last_d = !fit0;
			end
		end else if (!hold && (uw.op == OP_MISS)) begin
			emit_now = 1'b1;
			kind_d   = KIND_MISS;
			last_d   = !more;
		end else if (!hold && (uw.op == OP_HIT)) begin
			emit_now = 1'b1;
			kind_d   = KIND_HIT;
			px_d     = cx[8:0];
			py_d     = hit_y[8:0];
			last_d   = !more;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= ST_IDLE;
			ld_pos_q <= '0;
			m_tvalid <= 1'b0;
		end else begin
			step_q <= step_d;
			if (ld) begin
				ld_pos_q <= (ld_pos_q == AW'(PIXELS - 1)) ? '0 : ld_pos_q + AW'(1);
			end
			if (emit_now) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_now) begin
			m_tuser <= kind_d;
			m_tdata <= {{(M_TDATA_W-18){1'b0}}, py_d, px_d};
			m_tlast <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			top_q  <= '0;
			prev_q <= '0;
			m_q    <= '0;
			r_q    <= '0;
			side_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			unique case (uw.op)
				OP_ACCEPT: begin
					if (srch) begin
						prev_q <= sx;
						left_q <= l0;
						top_q  <= t0;
						side_q <= lane_side;
						cnt_q  <= '0;
					end
				end
				OP_COLINIT: begin
					m_q <= (side_q == SIDE_RIGHT) ? 6'(w_eff - 7'd1) : 6'd0;
					r_q <= '0;
				end
				OP_READ: begin
					r_q <= r_q + 7'd1;
				end
				OP_COLNEXT: begin
					r_q <= '0;
					m_q <= (side_q == SIDE_RIGHT) ? m_q - 6'd1 : m_q + 6'd1;
				end
				OP_MISS, OP_HIT: begin
					if (!hold) begin
						left_q <= nl;
						prev_q <= cx;
						top_q  <= nt;
						cnt_q  <= cnt_q + 6'd1;
					end
				end
				OP_NONE: begin
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[design/swlt_chk.sv]
// Port checker of the lane tracker and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module swlt_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [swlt_pkg::M_TDATA_W-1:0] m_tdata,
	input wire logic [swlt_pkg::M_TUSER_W-1:0] m_tuser,
	input wire logic                          m_tlast,
	input wire logic                          pready
);

	import swlt_pkg::*;

	`CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")
	`CHK_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")
	`CHK_SAME(a_nostart, m_tvalid && (m_tuser == KIND_NOSTART), m_tlast && (m_tdata == '0), "no-start beat not final or not zero")
	`CHK_SAME(a_miss_zero, m_tvalid && (m_tuser == KIND_MISS), m_tdata == '0, "miss beat carries a point")
	`CHK_SAME(a_pready, m_tvalid || !m_tvalid, pready, "pready dropped")

endmodule

bind sliding_window_lane_tracker swlt_chk u_chk (.*);
`default_nettype wire
